>>> sv/mtw_pkg.sv
// ----------------------------------------------------------------------------
// mtw_pkg
// Shared types, constants and register indexes of the medium throughput
// weight unit.
// ----------------------------------------------------------------------------
package mtw_pkg;

    localparam int MTW_FRAC_BITS = 16;

    localparam int COEF_W = 24;               // coefficient field width
    localparam int EXT_W  = COEF_W + 1;       // absorption plus scattering
    localparam int DIST_W = 32;               // segment length width
    localparam int X_W    = EXT_W + DIST_W;   // optical depth product
    localparam int TR_W   = 33;               // transmittance, Q.32 up to 1.0
    localparam int WGT_W  = 32;               // weight width
    localparam int NUM_W  = 60;               // three times the numerator

    localparam logic [24:0] LOG2E_Q24 = 25'd24204406;
    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    localparam logic [6:0]  K_LIMIT   = 7'd48;

    localparam int SERIES_TERMS = 13;

    // pipeline depths, one register per count
    localparam int EXP_LAT = 4 + 3 * (SERIES_TERMS - 1) + 1;
    localparam int WGT_LAT = 2;
    localparam int DIV_LAT = WGT_W + 2;
    localparam int LATENCY = EXP_LAT + WGT_LAT + DIV_LAT;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_MODE          = 3'd0,
        REG_ABSORB_RED    = 3'd1,
        REG_ABSORB_GREEN  = 3'd2,
        REG_ABSORB_BLUE   = 3'd3,
        REG_SCATTER_RED   = 3'd4,
        REG_SCATTER_GREEN = 3'd5,
        REG_SCATTER_BLUE  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic                   mode;
        logic [2:0][COEF_W-1:0] absorb;
        logic [2:0][COEF_W-1:0] scatter;
    } t_cfg;

    // running state of the exp series
    typedef struct packed {
        logic [31:0] t;
        logic [31:0] u;
        logic [32:0] acc;
        logic [5:0]  k;
        logic        zero;
    } t_series;

endpackage

>>> sv/mtw_regs.sv
// ----------------------------------------------------------------------------
// mtw_regs
// APB register file holding medium mode and per-channel coefficients.
// ----------------------------------------------------------------------------
module mtw_regs
    import mtw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[4:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (idx)
                REG_MODE:          n_cfg.mode       = pwdata[0];
                REG_ABSORB_RED:    n_cfg.absorb[0]  = pwdata[COEF_W-1:0];
                REG_ABSORB_GREEN:  n_cfg.absorb[1]  = pwdata[COEF_W-1:0];
                REG_ABSORB_BLUE:   n_cfg.absorb[2]  = pwdata[COEF_W-1:0];
                REG_SCATTER_RED:   n_cfg.scatter[0] = pwdata[COEF_W-1:0];
                REG_SCATTER_GREEN: n_cfg.scatter[1] = pwdata[COEF_W-1:0];
                REG_SCATTER_BLUE:  n_cfg.scatter[2] = pwdata[COEF_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg      <= '0;
            r_cfg.mode <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (idx)
            REG_MODE:          prdata = DATA_W'(r_cfg.mode);
            REG_ABSORB_RED:    prdata = DATA_W'(r_cfg.absorb[0]);
            REG_ABSORB_GREEN:  prdata = DATA_W'(r_cfg.absorb[1]);
            REG_ABSORB_BLUE:   prdata = DATA_W'(r_cfg.absorb[2]);
            REG_SCATTER_RED:   prdata = DATA_W'(r_cfg.scatter[0]);
            REG_SCATTER_GREEN: prdata = DATA_W'(r_cfg.scatter[1]);
            REG_SCATTER_BLUE:  prdata = DATA_W'(r_cfg.scatter[2]);
            default:           prdata = '0;
        endcase
    end

endmodule

>>> sv/mtw_term.sv
// ----------------------------------------------------------------------------
// mtw_term
// One term of the exp series: t = floor(floor(t * u / 2^32) / n), then added
// to or subtracted from the running sum. Three register stages.
// ----------------------------------------------------------------------------
module mtw_term
    import mtw_pkg::*;
#(
    parameter int DIVISOR = 2
) (
    input  logic    i_clk,
    input  t_series i_s,
    output t_series o_s
);

    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIVISOR);
    localparam bit          EVEN  = (DIVISOR % 2) == 0;

    t_series     r_sa, r_sb, r_sc;
    t_series     n_sa, n_sb, n_sc;
    logic [31:0] r_pb;
    logic [35:0] rem;
    logic [31:0] t_fix;

    // product of term and u
    always_comb begin
        n_sa   = i_s;
        n_sa.t = 32'((64'(i_s.t) * 64'(i_s.u)) >> 32);
    end

    // quotient estimate by reciprocal, at most one low
    always_comb begin
        n_sb   = r_sa;
        n_sb.t = 32'((64'(r_sa.t) * 64'(RECIP)) >> 32);
    end

    // correction and accumulation
    always_comb begin
        rem    = 36'(r_pb) - 36'(r_sb.t) * 36'(DIVISOR);
        t_fix  = r_sb.t + 32'(rem >= 36'(DIVISOR));
        n_sc   = r_sb;
        n_sc.t = t_fix;
        if (EVEN) begin
            n_sc.acc = r_sb.acc + 33'(t_fix);
        end else begin
            n_sc.acc = r_sb.acc - 33'(t_fix);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sa <= n_sa;
        r_sb <= n_sb;
        r_pb <= r_sa.t;
        r_sc <= n_sc;
    end

    assign o_s = r_sc;

endmodule

>>> sv/mtw_exp.sv
// ----------------------------------------------------------------------------
// mtw_exp
// Transmittance exp(-ext * dist) in Q.32 for one channel, fully pipelined:
// optical depth, range reduction by log2 e, power series of 2^-f, shift by k.
// ----------------------------------------------------------------------------
module mtw_exp
    import mtw_pkg::*;
#(
    parameter int FRAC_BITS = MTW_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic [EXT_W-1:0]  i_ext,
    input  logic [DIST_W-1:0] i_dist,
    output logic [TR_W-1:0]   o_tr
);

    localparam int HI_LSB = 2 * FRAC_BITS + 6;

    logic [X_W-1:0]      r_x;
    logic [37:0]         y;
    logic [56:0]         r_ylo;
    logic [30:0]         r_yhi;
    logic                r_big;
    logic [62:0]         zf;
    logic [31:0]         r_f;
    logic [5:0]          r_k;
    logic                r_zero;
    logic [31:0]         u;
    t_series             r_s0;
    t_series             chain [0:SERIES_TERMS-1];
    logic [TR_W-1:0]     r_tr;

    // 32 fraction bits
    assign y  = 38'(({r_x, 32'd0}) >> (2 * FRAC_BITS));
    assign zf = 63'(r_ylo) + (63'(r_yhi) << 32);
    assign u  = 32'((64'(r_f) * 64'(LN2_Q32)) >> 32);

    always_ff @(posedge i_clk) begin
        r_x    <= X_W'(i_ext) * X_W'(i_dist);
        r_ylo  <= 57'(y[31:0]) * 57'(LOG2E_Q24);
        r_yhi  <= 31'(y[37:32]) * 31'(LOG2E_Q24);
        r_big  <= |r_x[X_W-1:HI_LSB];
        r_f    <= zf[55:24];
        r_k    <= zf[61:56];
        r_zero <= r_big | (zf[62:56] >= K_LIMIT);
        r_s0.t    <= u;
        r_s0.u    <= u;
        r_s0.acc  <= 33'h1_0000_0000 - 33'(u);
        r_s0.k    <= r_k;
        r_s0.zero <= r_zero;
        r_tr   <= chain[SERIES_TERMS-1].zero ? '0 :
                  (chain[SERIES_TERMS-1].acc >> chain[SERIES_TERMS-1].k);
    end

    assign chain[0] = r_s0;

    for (genvar n = 2; n <= SERIES_TERMS; n++) begin : g_term
        mtw_term #(
            .DIVISOR (n)
        ) u_term (
            .i_clk (i_clk),
            .i_s   (chain[n-2]),
            .o_s   (chain[n-1])
        );
    end

    assign o_tr = r_tr;

endmodule

>>> sv/mtw_weight.sv
// ----------------------------------------------------------------------------
// mtw_weight
// Densities, numerators and density sum ahead of the divider. In absorption
// mode the weight is sent through as numerator over a divisor of one.
// ----------------------------------------------------------------------------
module mtw_weight
    import mtw_pkg::*;
#(
    parameter int FRAC_BITS = MTW_FRAC_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_scat,
    input  logic                   i_mode,
    input  logic [2:0][EXT_W-1:0]  i_ext,
    input  logic [2:0][COEF_W-1:0] i_scatter,
    input  logic [2:0][TR_W-1:0]   i_tr,
    output logic                   o_valid,
    output logic                   o_zero,
    output logic [59-FRAC_BITS:0]  o_den,
    output logic [2:0][NUM_W-1:0]  o_num
);

    localparam int DEN_W = 58 - FRAC_BITS;
    localparam int SUM_W = 60 - FRAC_BITS;

    logic                    r_v1, r_v2;
    logic                    r_mode1;
    logic [2:0][DEN_W-1:0]   r_den;
    logic [2:0][57:0]        r_num;
    logic [2:0][WGT_W-1:0]   r_wabs;
    logic [2:0][57:0]        prod;
    logic [2:0][EXT_W-1:0]   scale;
    logic [SUM_W-1:0]        sum;
    logic [SUM_W-1:0]        r_sum;
    logic                    r_zero;
    logic [2:0][NUM_W-1:0]   r_n;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            prod[c]  = 58'(i_ext[c]) * 58'(i_tr[c]);
            scale[c] = i_scat ? EXT_W'(i_scatter[c]) : (EXT_W'(1) << FRAC_BITS);
        end
        sum = SUM_W'(r_den[0]) + SUM_W'(r_den[1]) + SUM_W'(r_den[2]);
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_den[c]  <= i_scat ? DEN_W'(prod[c] >> FRAC_BITS) : DEN_W'(i_tr[c]);
            r_num[c]  <= 58'(i_tr[c]) * 58'(scale[c]);
            r_wabs[c] <= WGT_W'(i_tr[c] >> (32 - FRAC_BITS));
        end
        r_mode1 <= i_mode;
        // scattering mode: three times the numerator; absorption mode: weight over one
        for (int c = 0; c < 3; c++) begin
            r_n[c] <= r_mode1 ? (NUM_W'(r_num[c]) + (NUM_W'(r_num[c]) << 1))
                              : NUM_W'(r_wabs[c]);
        end
        r_sum  <= r_mode1 ? sum : SUM_W'(1);
        r_zero <= r_mode1 & (sum == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_zero  = r_zero;
    assign o_den   = r_sum;
    assign o_num   = r_n;

endmodule

>>> sv/mtw_div.sv
// ----------------------------------------------------------------------------
// mtw_div
// Pipelined restoring divider, one quotient bit per stage for three lanes
// sharing one divisor, with saturation and zero-divisor handling.
// ----------------------------------------------------------------------------
module mtw_div
    import mtw_pkg::*;
#(
    parameter int FRAC_BITS = MTW_FRAC_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_zero,
    input  logic [59-FRAC_BITS:0]  i_den,
    input  logic [2:0][NUM_W-1:0]  i_num,
    output logic                   o_valid,
    output logic [2:0][WGT_W-1:0]  o_weight,
    output logic                   o_saturated,
    output logic                   o_pdf_zero
);

    localparam int SW = 60 - FRAC_BITS;
    localparam int QB = WGT_W;

    logic [SW-1:0]    r_rem  [0:QB][0:2];
    logic [QB-1:0]    r_low  [0:QB][0:2];
    logic [QB-1:0]    r_quo  [0:QB][0:2];
    logic [2:0]       r_sat  [0:QB];
    logic [SW-1:0]    r_dvs  [0:QB];
    logic             r_zero [0:QB];
    logic             r_vld  [0:QB];

    logic [2:0][WGT_W-1:0] r_w;
    logic                  r_osat;
    logic                  r_ozero;
    logic                  r_ovld;

    // head: high part of the numerator checked against the divisor
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_rem[0][c] <= SW'(i_num[c][NUM_W-1:QB]);
            r_low[0][c] <= i_num[c][QB-1:0];
            r_quo[0][c] <= '0;
            r_sat[0][c] <= SW'(i_num[c][NUM_W-1:QB]) >= i_den;
        end
        r_dvs[0]  <= i_den;
        r_zero[0] <= i_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_bit
        logic [SW:0]   n_cat [0:2];
        logic          n_ge  [0:2];
        logic [SW-1:0] n_rem [0:2];

        always_comb begin
            for (int c = 0; c < 3; c++) begin
                n_cat[c] = {r_rem[j][c], r_low[j][c][QB-1]};
                n_ge[c]  = n_cat[c] >= {1'b0, r_dvs[j]};
                n_rem[c] = n_ge[c] ? SW'(n_cat[c] - {1'b0, r_dvs[j]}) : SW'(n_cat[c]);
            end
        end

        always_ff @(posedge i_clk) begin
            for (int c = 0; c < 3; c++) begin
                r_rem[j+1][c] <= n_rem[c];
                r_low[j+1][c] <= {r_low[j][c][QB-2:0], 1'b0};
                r_quo[j+1][c] <= {r_quo[j][c][QB-2:0], n_ge[c]};
            end
            r_sat[j+1]  <= r_sat[j];
            r_dvs[j+1]  <= r_dvs[j];
            r_zero[j+1] <= r_zero[j];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else begin
                r_vld[j+1] <= r_vld[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            if (r_zero[QB]) begin
                r_w[c] <= '0;
            end else if (r_sat[QB][c]) begin
                r_w[c] <= '1;
            end else begin
                r_w[c] <= r_quo[QB][c];
            end
        end
        r_osat  <= !r_zero[QB] && (|r_sat[QB]);
        r_ozero <= r_zero[QB];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= r_vld[QB];
        end
    end

    assign o_valid     = r_ovld;
    assign o_weight    = r_w;
    assign o_saturated = r_osat;
    assign o_pdf_zero  = r_ozero;

endmodule

>>> sv/medium_throughput_weight_unit.sv
// ----------------------------------------------------------------------------
// medium_throughput_weight_unit
// Per-channel throughput weight of a ray segment through a homogeneous medium.
// ----------------------------------------------------------------------------
// a segment is taken on every cycle that start is high; busy never rises, so
// one segment per clock is sustained. every result appears on o_valid exactly
// LATENCY (77) cycles after its start beat and is held for that one cycle
// only: the receiver must take it then, there is no back pressure. the depth
// comes from the exp pipeline (optical depth, range reduction, twelve series
// terms at three stages each) and the 32-stage restoring divider for the
// weight quotient. configuration is read live by the pipeline, so write it
// only while no segment is in flight. no memory, no clearing pass after reset
// ----------------------------------------------------------------------------
module medium_throughput_weight_unit
    import mtw_pkg::*;
#(
    parameter int FRAC_BITS = MTW_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // segment beat
    input  logic              start,
    output logic              busy,
    input  logic [DIST_W-1:0] i_seg_length,
    input  logic              i_scatter_event,
    // result beat
    output logic              o_valid,
    output logic [WGT_W-1:0]  o_weight_red,
    output logic [WGT_W-1:0]  o_weight_green,
    output logic [WGT_W-1:0]  o_weight_blue,
    output logic              o_saturated,
    output logic              o_pdf_zero,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg                    cfg;
    logic [2:0][EXT_W-1:0]   ext;
    logic [2:0][TR_W-1:0]    tr;

    // valid and scatter flag ride alongside the exp pipeline
    logic [EXP_LAT-1:0]      r_vld_line;
    logic [EXP_LAT-1:0]      r_scat_line;

    logic                    w_valid;
    logic                    w_zero;
    logic [59-FRAC_BITS:0]   w_den;
    logic [2:0][NUM_W-1:0]   w_num;
    logic [2:0][WGT_W-1:0]   weight;

    // pipeline never stalls
    assign busy = 1'b0;

    mtw_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // extinction per channel, scattering only counts in scattering mode
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            ext[c] = EXT_W'(cfg.absorb[c])
                   + (cfg.mode ? EXT_W'(cfg.scatter[c]) : EXT_W'(0));
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_chan
        mtw_exp #(
            .FRAC_BITS (FRAC_BITS)
        ) u_exp (
            .i_clk  (i_clk),
            .i_ext  (ext[c]),
            .i_dist (i_seg_length),
            .o_tr   (tr[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_line <= '0;
        end else begin
            r_vld_line <= {r_vld_line[EXP_LAT-2:0], start & ~busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_scat_line <= {r_scat_line[EXP_LAT-2:0], i_scatter_event};
    end

    // densities, numerators, sum of densities
    mtw_weight #(
        .FRAC_BITS (FRAC_BITS)
    ) u_weight (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_vld_line[EXP_LAT-1]),
        .i_scat    (r_scat_line[EXP_LAT-1]),
        .i_mode    (cfg.mode),
        .i_ext     (ext),
        .i_scatter (cfg.scatter),
        .i_tr      (tr),
        .o_valid   (w_valid),
        .o_zero    (w_zero),
        .o_den     (w_den),
        .o_num     (w_num)
    );

    // weight = 3 * num / density sum in scattering mode, num / 1 in absorption mode, saturated
    mtw_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_valid),
        .i_zero      (w_zero),
        .i_den       (w_den),
        .i_num       (w_num),
        .o_valid     (o_valid),
        .o_weight    (weight),
        .o_saturated (o_saturated),
        .o_pdf_zero  (o_pdf_zero)
    );

    assign o_weight_red   = weight[0];
    assign o_weight_green = weight[1];
    assign o_weight_blue  = weight[2];

`ifndef NO_ASSERTIONS
    // every result beat traces back to a start beat a fixed depth earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result beat without matching start beat");

    // zero density sum forces zero weights and no saturation
    a_pdf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pdf_zero) |-> (!o_saturated && o_weight_red == '0
            && o_weight_green == '0 && o_weight_blue == '0))
        else $error("pdf zero with nonzero weights or saturation");

    // saturation flag only with a clipped weight
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |-> (o_weight_red == '1
            || o_weight_green == '1 || o_weight_blue == '1))
        else $error("saturated without a clipped weight");

    // absorption mode raises no flags
    a_abs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !cfg.mode) |-> (!o_saturated && !o_pdf_zero))
        else $error("flag raised in absorption mode");
`endif

endmodule
